### rtl/core/csvfs_pkg.sv
`default_nettype none

package csvfs_pkg;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] COMMA_CHAR = 8'h2C;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic OUT_CONTENT = 1'b0;
    localparam logic OUT_END     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } t_req;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last_field;
        logic       space_overflow;
        logic       run_end;
    } t_res;

    // One command per request that produces output: either a content byte
    // preceded by the held whitespace, or an end-of-field mark.
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_FINAL
    } t_back_state;

endpackage

`default_nettype wire

### rtl/core/csvfs_ram.sv
`default_nettype none

module csvfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/csvfs_front.sv
`default_nettype none

module csvfs_front #(
    parameter int MAX_HELD_SPACES = 16,
    localparam int CW = $clog2(MAX_HELD_SPACES + 1),
    localparam int AW = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire csvfs_pkg::t_req   i_in_req,
    output logic                   o_in_stall,
    output logic                   o_push,
    output csvfs_pkg::t_cmd        o_cmd,
    output logic [CW-1:0]          o_cmd_count,
    input  wire logic              i_fifo_full,
    output logic                   o_ram_we,
    output logic [AW-1:0]          o_ram_waddr,
    output logic [7:0]             o_ram_wdata,
    input  wire logic              i_held_read
);

    import csvfs_pkg::*;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HELD_SPACES);

    logic          r_quoting, n_quoting;
    logic          r_qpend, n_qpend;
    logic          r_started, n_started;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_inflight, n_inflight;

    logic          eol;
    logic [7:0]    b;
    logic          handled;
    logic          quoting_eff;
    logic          do_content;
    logic [7:0]    c_byte;
    logic          end_mark;
    logic          last;
    logic          emit;
    logic          we;
    logic          accept;

    function automatic logic is_ws(input logic [7:0] v);
        return (v >= 8'd9 && v <= 8'd13) || v == 8'd32;
    endfunction

    assign eol = (i_in_req.kind == KIND_EOL);
    assign b   = i_in_req.in_byte;

    always_comb begin
        handled     = 1'b0;
        quoting_eff = r_quoting;
        do_content  = 1'b0;
        c_byte      = b;
        end_mark    = 1'b0;
        last        = 1'b0;
        n_quoting   = r_quoting;
        n_qpend     = 1'b0;

        // A quote seen inside quoting is resolved by the byte after it.
        if (r_qpend) begin
            if (!eol && b == QUOTE_CHAR) begin
                do_content = 1'b1;
                c_byte     = QUOTE_CHAR;
                handled    = 1'b1;
            end else begin
                quoting_eff = 1'b0;
            end
        end

        if (!handled) begin
            n_quoting = quoting_eff;
            if (eol) begin
                end_mark  = 1'b1;
                last      = 1'b1;
                n_quoting = 1'b0;
            end else if (quoting_eff) begin
                if (b == QUOTE_CHAR) begin
                    n_qpend = 1'b1;
                end else begin
                    do_content = 1'b1;
                end
            end else if (b == QUOTE_CHAR) begin
                n_quoting = 1'b1;
            end else if (b == COMMA_CHAR) begin
                end_mark = 1'b1;
            end else begin
                do_content = 1'b1;
            end
        end
    end

    always_comb begin
        emit      = 1'b0;
        we        = 1'b0;
        n_started = r_started;
        n_ovf     = r_ovf;
        n_count   = r_count;

        if (end_mark) begin
            emit      = 1'b1;
            n_started = 1'b0;
            n_ovf     = 1'b0;
            n_count   = '0;
        end else if (do_content) begin
            if (is_ws(c_byte)) begin
                if (r_started) begin
                    if (r_count < MAX_CNT) begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end else begin
                emit      = 1'b1;
                n_started = 1'b1;
                n_count   = '0;
            end
        end
    end

    // The store is reused from entry zero, so a new whitespace byte waits
    // until the back end has read out every entry of an earlier release.
    assign o_in_stall = (emit && i_fifo_full) || (we && r_inflight != '0);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_push        = accept && emit;
    assign o_cmd.is_end  = end_mark;
    assign o_cmd.data    = end_mark ? 8'd0 : c_byte;
    assign o_cmd.last    = last;
    assign o_cmd.ovf     = r_ovf;
    assign o_cmd_count   = end_mark ? '0 : r_count;

    assign o_ram_we    = accept && we;
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = c_byte;

    always_comb begin
        n_inflight = r_inflight;
        if (o_push) begin
            n_inflight = n_inflight + o_cmd_count;
        end
        if (i_held_read) begin
            n_inflight = n_inflight - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoting  <= 1'b0;
            r_qpend    <= 1'b0;
            r_started  <= 1'b0;
            r_ovf      <= 1'b0;
            r_count    <= '0;
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
            if (accept) begin
                r_quoting <= n_quoting;
                r_qpend   <= n_qpend;
                r_started <= n_started;
                r_ovf     <= n_ovf;
                r_count   <= n_count;
            end
        end
    end

    a_write_only_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> r_inflight == '0
    ) else $error("whitespace store written while a release is still reading it");

    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT
    ) else $error("held whitespace count beyond store depth");

    a_read_needs_inflight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_held_read |-> r_inflight != '0
    ) else $error("held byte delivered with no release outstanding");

endmodule

`default_nettype wire

### rtl/core/csvfs_cmd_fifo.sv
`default_nettype none

module csvfs_cmd_fifo #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overrun: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty)
    ) else $error("command queue pushed while full or popped while empty");

endmodule

`default_nettype wire

### rtl/core/csvfs_back.sv
`default_nettype none

module csvfs_back #(
    parameter int MAX_HELD_SPACES = 16,
    localparam int CW = $clog2(MAX_HELD_SPACES + 1),
    localparam int AW = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire csvfs_pkg::t_cmd   i_cmd,
    input  wire logic [CW-1:0]     i_cmd_count,
    output logic                   o_pop,
    output logic                   o_ram_re,
    output logic [AW-1:0]          o_ram_raddr,
    input  wire logic [7:0]        i_ram_rdata,
    output logic                   o_held_read,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output csvfs_pkg::t_res        o_out_res
);

    import csvfs_pkg::*;

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    t_res          r_out;

    logic          can_load;
    logic          load;
    t_res          load_data;
    t_res          final_res;
    t_res          held_res;

    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        final_res.out_kind       = i_cmd.is_end ? OUT_END : OUT_CONTENT;
        final_res.out_byte       = i_cmd.data;
        final_res.last_field     = i_cmd.last;
        final_res.space_overflow = i_cmd.ovf;
        final_res.run_end        = 1'b1;

        held_res.out_kind       = OUT_CONTENT;
        held_res.out_byte       = i_ram_rdata;
        held_res.last_field     = 1'b0;
        held_res.space_overflow = i_cmd.ovf;
        held_res.run_end        = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx[AW-1:0];
        o_held_read = 1'b0;
        load        = 1'b0;
        load_data   = final_res;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd_count != '0) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = '0;
                        n_idx       = CW'(1);
                        n_state     = ST_FLUSH;
                    end else if (can_load) begin
                        load  = 1'b1;
                        o_pop = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                // Read data stays in the RAM register until the next read.
                if (can_load) begin
                    load        = 1'b1;
                    load_data   = held_res;
                    o_held_read = 1'b1;
                    if (r_idx < i_cmd_count) begin
                        o_ram_re = 1'b1;
                        n_idx    = r_idx + CW'(1);
                    end else begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (can_load) begin
                    load    = 1'b1;
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= load_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    a_flush_index_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> (r_idx != '0 && r_idx <= i_cmd_count && i_cmd_valid)
    ) else $error("release index outside the command's held count");

endmodule

`default_nettype wire

### rtl/core/csv_field_splitter_core.sv
// Channel  | Direction | Payload                   | Request taken when
// ---------+-----------+---------------------------+-------------------------------
// input    | in        | i_in_req   (t_req)        | i_in_valid high, o_in_stall low
// result   | out       | o_out_res  (t_res)        | o_out_valid high, i_out_stall low
//
// The front end takes one request per cycle while the two-entry command queue has room.
// A result with no held whitespace is loaded from the queue head into the output register; a release
// of N held bytes issues one store read per byte, sends each held byte, then the final result.
// A whitespace request that must be stored waits while an earlier release still reads the store.
// Reset is synchronous and clears all control state; the whitespace store needs no clearing.
// Results sit in one output register; while the output stalls the queue fills, then the input.
`default_nettype none

module csv_field_splitter_core #(
    parameter int MAX_HELD_SPACES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire csvfs_pkg::t_req i_in_req,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output csvfs_pkg::t_res      o_out_res
);

    import csvfs_pkg::*;

    localparam int CW    = $clog2(MAX_HELD_SPACES + 1);
    localparam int AW    = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
    localparam int CMD_W = $bits(t_cmd);
    localparam int QW    = CMD_W + CW;

    logic          push;
    t_cmd          front_cmd;
    logic [CW-1:0] front_count;
    logic          fifo_full;
    logic          fifo_empty;
    logic          pop;
    logic [QW-1:0] fifo_dout;
    t_cmd          head_cmd;
    logic [CW-1:0] head_count;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          held_read;

    csvfs_front #(
        .MAX_HELD_SPACES (MAX_HELD_SPACES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_cmd_count (front_count),
        .i_fifo_full (fifo_full),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_held_read (held_read)
    );

    csvfs_cmd_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_count, front_cmd}),
        .i_pop   (pop),
        .o_data  (fifo_dout),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    assign head_cmd   = t_cmd'(fifo_dout[CMD_W-1:0]);
    assign head_count = fifo_dout[QW-1:CMD_W];

    csvfs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_HELD_SPACES)
    ) u_held_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    csvfs_back #(
        .MAX_HELD_SPACES (MAX_HELD_SPACES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!fifo_empty),
        .i_cmd       (head_cmd),
        .i_cmd_count (head_count),
        .o_pop       (pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_held_read (held_read),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csvfs_pkg::*;

    localparam int MAX_HELD = 16;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        t_req       req;
        logic [4:0] reps;
        logic       typed;
        t_res       want;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_req i_in_req = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_res;

    csv_field_splitter_core #(
        .MAX_HELD_SPACES(MAX_HELD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    always #1 i_clk = ~i_clk;

    // Splitter state as seen from outside.
    bit         quote_open;
    bit         quote_seen;
    bit         field_live;
    logic [7:0] held_ws [MAX_HELD];
    int         n_held;
    bit         ws_dropped;

    t_res  field_out_q[$];
    t_step steps_q[$];
    t_res  due;
    int    errors;
    int    n_sent;
    int    quiet_cycles;
    bit    idle_on;
    bit    hold_ask;
    int    hold_left;
    int    out_burst;

    function automatic bit ws_code(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
    endfunction

    function automatic logic [7:0] space_byte();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? 8'd32 : 8'(9 + v);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (ws_code(b) || b == QUOTE_CHAR || b == COMMA_CHAR);
        return b;
    endfunction

    function automatic string show(input t_res r);
        return $sformatf("kind=%0d byte=%02h last=%0d ovf=%0d end=%0d", r.out_kind,
                         r.out_byte, r.last_field, r.space_overflow, r.run_end);
    endfunction

    task automatic emit(input logic k, input logic [7:0] b, input logic last);
        field_out_q.insert(field_out_q.size(), {k, b, last, ws_dropped, 1'b0});
    endtask

    task automatic end_field();
        field_live = 1'b0;
        n_held = 0;
        ws_dropped = 1'b0;
    endtask

    // Whitespace after content is held back; anything else releases it first.
    task automatic take_content(input logic [7:0] b);
        if (ws_code(b)) begin
            if (field_live) begin
                if (n_held < MAX_HELD) begin
                    held_ws[n_held] = b;
                    n_held++;
                end else begin
                    ws_dropped = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < n_held; i++) emit(OUT_CONTENT, held_ws[i], 1'b0);
            n_held = 0;
            field_live = 1'b1;
            emit(OUT_CONTENT, b, 1'b0);
        end
    endtask

    task automatic split_byte(input t_req r);
        int   n0;
        bit   eol;
        bit   doubled;
        t_res tail;
        n0 = field_out_q.size();
        eol = (r.kind == KIND_EOL);
        doubled = 1'b0;
        if (quote_seen) begin
            quote_seen = 1'b0;
            if (!eol && r.in_byte == QUOTE_CHAR) begin
                take_content(QUOTE_CHAR);
                doubled = 1'b1;
            end else begin
                quote_open = 1'b0;
            end
        end
        if (!doubled) begin
            if (eol) begin
                quote_open = 1'b0;
                emit(OUT_END, 8'h00, 1'b1);
                end_field();
            end else if (quote_open) begin
                if (r.in_byte == QUOTE_CHAR) quote_seen = 1'b1;
                else take_content(r.in_byte);
            end else if (r.in_byte == QUOTE_CHAR) begin
                quote_open = 1'b1;
            end else if (r.in_byte == COMMA_CHAR) begin
                emit(OUT_END, 8'h00, 1'b0);
                end_field();
            end else begin
                take_content(r.in_byte);
            end
        end
        if (field_out_q.size() > n0) begin
            tail = field_out_q.pop_back();
            tail.run_end = 1'b1;
            field_out_q.insert(field_out_q.size(), tail);
        end
    endtask

    task automatic send(input t_req r, input bit typed, input t_res want);
        int n0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        do @(posedge i_clk); while (o_in_stall);
        n0 = field_out_q.size();
        split_byte(r);
        if (typed) begin
            while (field_out_q.size() > n0) void'(field_out_q.pop_back());
            field_out_q.insert(field_out_q.size(), want);
        end
        n_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send({KIND_BYTE, b}, 1'b0, '0);
    endtask

    task automatic put_eol();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send({KIND_EOL, junk}, 1'b0, '0);
    endtask

    // Lowers valid and waits on the clock until no result is still due.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (field_out_q.size() != 0);
    endtask

    task automatic add_step(input logic k, input logic [7:0] b, input int reps,
                            input bit typed, input t_res want);
        steps_q.insert(steps_q.size(), {k, b, 5'(reps), typed, want});
    endtask

    task automatic send_field();
        repeat ($urandom_range(0, 2)) put_byte(space_byte());
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 4)) put_byte(text_byte());
                1: repeat (($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(1, 3))
                    put_byte(space_byte());
                default: begin
                    put_byte(QUOTE_CHAR);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 4))
                            0: put_byte(space_byte());
                            1: put_byte(COMMA_CHAR);
                            2: begin
                                put_byte(QUOTE_CHAR);
                                put_byte(QUOTE_CHAR);
                            end
                            default: put_byte(text_byte());
                        endcase
                    end
                    // Now and then the quote stays open until a later byte or the line end.
                    if ($urandom_range(0, 7) != 0) put_byte(QUOTE_CHAR);
                end
            endcase
        end
        repeat ($urandom_range(0, 2)) put_byte(space_byte());
    endtask

    task automatic send_line();
        int nf;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) put_byte(COMMA_CHAR);
            send_field();
        end
        put_eol();
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0: b = QUOTE_CHAR;
                1: b = COMMA_CHAR;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send({($urandom_range(0, 7) == 0) ? KIND_EOL : KIND_BYTE, b}, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (field_out_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %s", $time,
                         show(o_out_res));
                errors++;
            end else begin
                due = field_out_q.pop_front();
                if (o_out_res !== due) begin
                    $display("%0t: result mismatch, expected %s, actual %s", $time,
                             show(due), show(o_out_res));
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 80;
            i_out_stall <= 1'b1;
        end else if (!idle_on) begin
            out_burst = 0;
            i_out_stall <= 1'b0;
        end else if (out_burst > 0) begin
            out_burst--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_burst = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        bit held_once;
        bit paused_once;
        held_once = 1'b0;
        paused_once = 1'b0;
        idle_on = 1'b1;

        add_step(KIND_EOL,  8'hFF, 1, 1, {OUT_END, 8'h00, 1'b1, 1'b0, 1'b1});
        add_step(KIND_BYTE, COMMA_CHAR, 1, 1, {OUT_END, 8'h00, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, 8'h00, 1, 1, {OUT_CONTENT, 8'h00, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, 8'hFF, 1, 1, {OUT_CONTENT, 8'hFF, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, 8'h20, 1, 0, '0);
        add_step(KIND_BYTE, 8'h09, 1, 0, '0);
        add_step(KIND_BYTE, 8'h0D, 1, 0, '0);
        add_step(KIND_BYTE, 8'h78, 1, 0, '0);
        add_step(KIND_BYTE, COMMA_CHAR, 1, 1, {OUT_END, 8'h00, 1'b0, 1'b0, 1'b1});
        // Leading whitespace is dropped, quoted or not.
        add_step(KIND_BYTE, 8'h20, 1, 0, '0);
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_BYTE, 8'h20, 1, 0, '0);
        add_step(KIND_BYTE, 8'h61, 1, 1, {OUT_CONTENT, 8'h61, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 1, {OUT_CONTENT, QUOTE_CHAR, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, COMMA_CHAR, 1, 1, {OUT_CONTENT, COMMA_CHAR, 1'b0, 1'b0, 1'b1});
        // A closing quote followed by a plain byte just continues the field.
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_BYTE, 8'h62, 1, 1, {OUT_CONTENT, 8'h62, 1'b0, 1'b0, 1'b1});
        // One more whitespace byte than the store holds.
        add_step(KIND_BYTE, 8'h0B, MAX_HELD + 1, 0, '0);
        add_step(KIND_BYTE, 8'h63, 1, 0, '0);
        add_step(KIND_BYTE, 8'h0C, 1, 0, '0);
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_EOL,  8'h00, 1, 1, {OUT_END, 8'h00, 1'b1, 1'b1, 1'b1});
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_BYTE, 8'h64, 1, 1, {OUT_CONTENT, 8'h64, 1'b0, 1'b0, 1'b1});
        add_step(KIND_BYTE, QUOTE_CHAR, 1, 0, '0);
        add_step(KIND_EOL,  8'h5A, 1, 1, {OUT_END, 8'h00, 1'b1, 1'b0, 1'b1});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps_q[k])
            repeat (steps_q[k].reps) send(steps_q[k].req, steps_q[k].typed, steps_q[k].want);
        drain();

        while (n_sent < 420) begin
            idle_on = (n_sent > 360) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (n_sent >= 150 && !held_once) begin
                // Output held off while requests keep coming, so the block backs up.
                held_once = 1'b1;
                hold_ask = 1'b1;
                idle_on = 1'b0;
                repeat (24) put_byte(text_byte());
                put_eol();
            end else if (n_sent >= 250 && !paused_once) begin
                paused_once = 1'b1;
                drain();
            end else if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end else begin
                send_line();
            end
        end
        drain();
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### csv_field_splitter_core.f
rtl/core/csvfs_pkg.sv
rtl/core/csvfs_ram.sv
rtl/core/csvfs_front.sv
rtl/core/csvfs_cmd_fifo.sv
rtl/core/csvfs_back.sv
rtl/core/csv_field_splitter_core.sv
tb/tb.sv
